[src/tta_pkg.sv]
// Shared types and constants for the tensor transpose address generator.
package tta_pkg;

	localparam int RANK_W     = 3;
	localparam int PERM_W     = 18;
	localparam int PFIELD_W   = 3;
	localparam int EXT_W      = 13;
	localparam int NUM_EXT    = 6;
	localparam int OUT_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_IDX_W-1:0] CFG_RANK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERM = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXT0 = 3'd2;

	localparam logic [RANK_W-1:0] RANK_RST = 3'd4;
	localparam logic [PERM_W-1:0] PERM_RST = 18'd181896;
	localparam logic [EXT_W-1:0]  EXT_RST  = 13'd1;

	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [RANK_W-1:0]             rank;
		logic [PERM_W-1:0]             perm;
		logic [NUM_EXT-1:0][EXT_W-1:0] ext;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic restart;
	} q_head_t;

endpackage

[src/tta_front.sv]
// Request intake: accepts requests, classifies restart/advance and queues them.
module tta_front import tta_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    restart,
	input  logic    q_pop,
	output q_head_t q_head
);

	logic [QDEPTH-1:0] ent_q;
	logic [QPW-1:0]    wr_q;
	logic [QPW-1:0]    rd_q;
	logic [QCW-1:0]    cnt_q;
	logic              push;

	function automatic logic [QPW-1:0] ptr_nxt(input logic [QPW-1:0] p);
		if (p == QPW'(QDEPTH - 1))
			return '0;
		return p + QPW'(1);
	endfunction

	assign in_stall       = (cnt_q == QCW'(QDEPTH));
	assign push           = in_valid && !in_stall;
	assign q_head.valid   = (cnt_q != '0);
	assign q_head.restart = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= restart;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ptr_nxt(wr_q);
			if (q_pop)
				rd_q <= ptr_nxt(rd_q);
			if (push && !q_pop)
				cnt_q <= cnt_q + QCW'(1);
			else if (!push && q_pop)
				cnt_q <= cnt_q - QCW'(1);
		end
	end

endmodule

[src/tta_back.sv]
// Execution engine: stride setup sequencer, output odometer and output register.
module tta_back import tta_pkg::*; #(
	parameter int MAX_RANK    = 6,
	parameter int EXTENT_BITS = 12,
	parameter int OFFSET_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  q_head_t          q_head,
	output logic             q_pop,
	input  logic             out_stall,
	output logic             out_valid,
	output logic [OUT_W-1:0] src_offset,
	output logic [OUT_W-1:0] dst_offset,
	output logic             last_elem,
	output logic             valid_out
);

	localparam int AW  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int JW  = $clog2(MAX_RANK + 1);
	localparam int EB  = EXTENT_BITS;
	localparam int EW  = EXTENT_BITS + 1;
	localparam int OB  = OFFSET_BITS;
	localparam int CW  = (EXT_W > EW) ? EXT_W : EW;
	localparam logic [CW-1:0] EXT_CAP = CW'(1) << EXTENT_BITS;

	localparam logic [2:0] ST_RUN  = 3'd0;
	localparam logic [2:0] ST_INIT = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_ADD  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]    state_q;
	logic [EB-1:0] idx_q [MAX_RANK];
	logic [EB-1:0] lim_q [MAX_RANK];
	logic [OB-1:0] dlt_q [MAX_RANK];
	logic [OB-1:0] ro_q;
	logic [OB-1:0] wc_q;
	logic          active_q;
	logic [JW-1:0] rank_q;
	logic [AW-1:0] ax_q;
	logic [JW-1:0] j_q;
	logic [OB-1:0] s_q;
	logic [EB-1:0] lm_q;
	logic [OB-1:0] prod_q;
	logic [OB-1:0] rsum_q;

	logic             out_valid_q;
	logic [OUT_W-1:0] src_q;
	logic [OUT_W-1:0] dst_q;
	logic             last_q;
	logic             vout_q;

	logic [EW-1:0]       ext_eff_a [MAX_RANK + 1];
	logic [PFIELD_W-1:0] pf_a [MAX_RANK];
	logic [3:0]          rk4;
	logic [JW-1:0]       r_eff;
	logic [PFIELD_W-1:0] src_a;
	logic [JW-1:0]       src_j;
	logic [OB+EW-1:0]    mul_full;
	logic [OB+EB-1:0]    acc_full;
	logic                last;
	logic [AW-1:0]       sel;
	logic                can_load;
	logic                ld;
	logic [OUT_W-1:0]    ld_src;
	logic [OUT_W-1:0]    ld_dst;
	logic                ld_last;
	logic                ld_vout;

	function automatic logic [EW-1:0] clamp_ext(input logic [EXT_W-1:0] e);
		logic [CW-1:0] v;
		v = CW'(e);
		if (v == '0)
			v = CW'(1);
		else if (v > EXT_CAP)
			v = EXT_CAP;
		return EW'(v);
	endfunction

	// effective extent per input axis, clamped; axes without a register are size 1
	for (genvar k = 0; k <= MAX_RANK; k++) begin : g_ext
		if (k < NUM_EXT) begin : g_reg
			assign ext_eff_a[k] = clamp_ext(cfg.ext[k]);
		end else begin : g_one
			assign ext_eff_a[k] = EW'(1);
		end
	end

	for (genvar k = 0; k < MAX_RANK; k++) begin : g_pf
		if (PFIELD_W * k + PFIELD_W <= PERM_W) begin : g_fld
			assign pf_a[k] = cfg.perm[PFIELD_W*k +: PFIELD_W];
		end else begin : g_zero
			assign pf_a[k] = '0;
		end
	end

	always_comb begin
		rk4 = {1'b0, cfg.rank};
		if (rk4 < 4'd2)
			r_eff = JW'(2);
		else if (rk4 > 4'(MAX_RANK))
			r_eff = JW'(MAX_RANK);
		else
			r_eff = JW'(rk4);
	end

	assign src_a    = pf_a[ax_q];
	assign src_j    = JW'(src_a);
	assign mul_full = s_q * ext_eff_a[j_q];
	assign acc_full = lm_q * s_q;

	// odometer: innermost axis below its limit takes the carry
	always_comb begin
		last = 1'b1;
		sel  = '0;
		for (int k = 0; k < MAX_RANK; k++) begin
			if (idx_q[k] != lim_q[k])
				last = 1'b0;
			if (idx_q[k] < lim_q[k])
				sel = AW'(k);
		end
	end

	assign can_load = !out_valid_q || !out_stall;

	always_comb begin
		q_pop   = 1'b0;
		ld      = 1'b0;
		ld_src  = '0;
		ld_dst  = '0;
		ld_last = 1'b0;
		ld_vout = 1'b0;
		if (state_q == ST_RUN && q_head.valid && !q_head.restart && can_load) begin
			q_pop = 1'b1;
			ld    = 1'b1;
			if (active_q) begin
				ld_src  = OUT_W'(ro_q);
				ld_dst  = OUT_W'(wc_q);
				ld_last = last;
				ld_vout = 1'b1;
			end
		end
		if (state_q == ST_DONE && can_load) begin
			q_pop = 1'b1;
			ld    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			src_q  <= ld_src;
			dst_q  <= ld_dst;
			last_q <= ld_last;
			vout_q <= ld_vout;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= ld;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_RUN;
			active_q <= 1'b0;
			ro_q     <= '0;
			wc_q     <= '0;
			rank_q   <= '0;
			ax_q     <= '0;
			j_q      <= '0;
			s_q      <= '0;
			lm_q     <= '0;
			prod_q   <= '0;
			rsum_q   <= '0;
			for (int k = 0; k < MAX_RANK; k++) begin
				idx_q[k] <= '0;
				lim_q[k] <= '0;
				dlt_q[k] <= '0;
			end
		end else begin
			case (state_q)
				ST_RUN: begin
					if (q_head.valid && q_head.restart) begin
						rank_q   <= r_eff;
						ax_q     <= AW'(r_eff - JW'(1));
						rsum_q   <= '0;
						ro_q     <= '0;
						wc_q     <= '0;
						active_q <= 1'b0;
						for (int k = 0; k < MAX_RANK; k++) begin
							idx_q[k] <= '0;
							lim_q[k] <= '0;
						end
						state_q <= ST_INIT;
					end else if (q_pop && active_q) begin
						if (last) begin
							active_q <= 1'b0;
						end else begin
							wc_q <= wc_q + OB'(1);
							ro_q <= ro_q + dlt_q[sel];
							for (int k = 0; k < MAX_RANK; k++) begin
								if (AW'(k) == sel)
									idx_q[k] <= idx_q[k] + EB'(1);
								else if (AW'(k) > sel)
									idx_q[k] <= '0;
							end
						end
					end
				end
				ST_INIT: begin
					s_q <= OB'(1);
					if (src_a >= rank_q) begin
						lm_q    <= '0;
						state_q <= ST_ACC;
					end else begin
						lm_q    <= EB'(ext_eff_a[src_j] - EW'(1));
						j_q     <= src_j + JW'(1);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (j_q < rank_q) begin
						s_q <= mul_full[OB-1:0];
						j_q <= j_q + JW'(1);
					end else begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					// carry delta: own stride minus rewind of all inner axes
					lim_q[ax_q] <= lm_q;
					dlt_q[ax_q] <= s_q - rsum_q;
					prod_q      <= acc_full[OB-1:0];
					state_q     <= ST_ADD;
				end
				ST_ADD: begin
					rsum_q <= rsum_q + prod_q;
					if (ax_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						ax_q    <= ax_q - AW'(1);
						state_q <= ST_INIT;
					end
				end
				ST_DONE: begin
					if (can_load) begin
						active_q <= 1'b1;
						state_q  <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign src_offset = src_q;
	assign dst_offset = dst_q;
	assign last_elem  = last_q;
	assign valid_out  = vout_q;

endmodule

[src/tensor_transpose_address_gen_top.sv]
// Top level of the tensor transpose address generator: config registers and engines.
//
//  channel  direction  handshake               payload
//  cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//  in       in         in_valid / in_stall     restart
//  out      out        out_valid / out_stall   src_offset, dst_offset, last_elem, valid_out
//
//  Advance requests issue one address pair per cycle while the output is not stalled and no
//  restart is running; the odometer carry add sets that. A restart runs the stride sequencer:
//  per output axis init, multiply steps (none when its perm field is not below rank), accumulate, add.
//  Reset clears the odometer and leaves the generator idle; cfg_ready is always high.
//  A two-entry request queue buffers intake while the output is stalled.
module tensor_transpose_address_gen_top import tta_pkg::*; #(
	parameter int MAX_RANK    = 6,
	parameter int EXTENT_BITS = 12,
	parameter int OFFSET_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [OUT_W-1:0]      src_offset,
	output logic [OUT_W-1:0]      dst_offset,
	output logic                  last_elem,
	output logic                  valid_out
);

	cfg_t    cfg_q;
	q_head_t q_head;
	logic    q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rank <= RANK_RST;
			cfg_q.perm <= PERM_RST;
			for (int k = 0; k < NUM_EXT; k++)
				cfg_q.ext[k] <= EXT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_RANK)
				cfg_q.rank <= cfg_data[RANK_W-1:0];
			if (cfg_index == CFG_PERM)
				cfg_q.perm <= cfg_data[PERM_W-1:0];
			for (int k = 0; k < NUM_EXT; k++)
				if (cfg_index == CFG_EXT0 + CFG_IDX_W'(k))
					cfg_q.ext[k] <= cfg_data[EXT_W-1:0];
		end
	end

	tta_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.restart  (restart),
		.q_pop    (q_pop),
		.q_head   (q_head)
	);

	tta_back #(
		.MAX_RANK    (MAX_RANK),
		.EXTENT_BITS (EXTENT_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.src_offset (src_offset),
		.dst_offset (dst_offset),
		.last_elem  (last_elem),
		.valid_out  (valid_out)
	);

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head.valid)
		else $error("queue popped while empty");

	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		q_head.valid && !q_pop |=> q_head.valid && q_head.restart == $past(q_head.restart))
		else $error("queue head changed without a pop");

	a_pop_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid)
		else $error("retired request produced no result");

endmodule
